>>> rtl/core/ctmon_pkg.sv
// Shared types and constants of the core temperature maximum threshold monitor.
package ctmon_pkg;

	// Default configuration of the block.
	localparam int DEF_MAX_CORES  = 32;
	localparam int DEF_TEMP_WIDTH = 20;

	// Width of the valid core count field in a result.
	localparam int VALID_CORES_WIDTH = 6;

	// Four alarms, in the order they are packed into a result.
	localparam int ALARM_COUNT = 4;
	localparam int ALM_WARN_HIGH = 0;
	localparam int ALM_WARN_LOW  = 1;
	localparam int ALM_CRIT_HIGH = 2;
	localparam int ALM_CRIT_LOW  = 3;

	// Result layout above the temperature field: functional flag, count,
	// alarm levels and alarm edges.
	localparam int RES_EXTRA_BITS = 1 + VALID_CORES_WIDTH + 2 * ALARM_COUNT;

	// Reset values of the configuration registers, in millidegrees.
	localparam int CLAMP_LOW_RESET  = -40000;
	localparam int CLAMP_HIGH_RESET = 125000;
	localparam int WARN_LOW_RESET   = -20000;
	localparam int WARN_HIGH_RESET  = 80000;
	localparam int CRIT_LOW_RESET   = -40000;
	localparam int CRIT_HIGH_RESET  = 95000;

	localparam int CFG_INDEX_WIDTH = 3;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_CLAMP_LOW  = 3'd0,
		REG_CLAMP_HIGH = 3'd1,
		REG_WARN_LOW   = 3'd2,
		REG_WARN_HIGH  = 3'd3,
		REG_CRIT_LOW   = 3'd4,
		REG_CRIT_HIGH  = 3'd5
	} cfg_reg_t;

endpackage

>>> rtl/core/core_temp_max_threshold_monitor_top.sv
// Top level of the core temperature maximum threshold monitor.
//
//  Channel  Direction  Handshake               Payload
//  s_*      in         s_tvalid / s_tready     tdata: reading; tuser: reading_ok;
//                                              tlast: round_last
//  m_*      out        m_tvalid / m_tready     tdata: aggregate_temp, sensor_functional,
//                                              valid_cores, alarm levels, alarm edges
//  cfg_*    in         cfg_valid / cfg_ready   cfg_index: register, cfg_data: value
//
// One request is taken in every clock cycle while the result side keeps up; the request
// carrying tlast passes through stage 1, stage 2, which holds the round's maximum and
// count, stage 3, which holds the clamped value, and the output register, which holds
// the alarm levels and edges. A reading that closes no round only updates the running
// maximum and count as it leaves stage 1.
// Ready falls only when the output register holds an untaken result, every stage behind it
// is full and stage 1 holds a round's last reading, so requests flow while a result waits.
// Reset is asynchronous and active low; it empties the pipeline, sets the running maximum
// to the most negative value, clears the count and the alarms, and loads the register defaults.
// Configuration writes are always accepted and take effect on the next cycle.
module core_temp_max_threshold_monitor_top
	import ctmon_pkg::*;
#(
	parameter int MAX_CORES  = DEF_MAX_CORES,
	parameter int TEMP_WIDTH = DEF_TEMP_WIDTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Reading requests.
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// Bits from 0: reading (TEMP_WIDTH bits, signed), then zero padding.
	input  logic [((TEMP_WIDTH+7)/8)*8-1:0]       s_tdata,
	// Bit 0: reading_ok.
	input  logic                                  s_tuser,
	input  logic                                  s_tlast,
	// Round results.
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// Bits from 0: aggregate_temp (TEMP_WIDTH, signed), sensor_functional,
	// valid_cores (6), warn_high_alarm, warn_low_alarm, crit_high_alarm,
	// crit_low_alarm, warn_high_edge, warn_low_edge, crit_high_edge,
	// crit_low_edge, then zero padding.
	output logic [((TEMP_WIDTH+RES_EXTRA_BITS+7)/8)*8-1:0] m_tdata,
	// Configuration writes.
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [CFG_INDEX_WIDTH-1:0]            cfg_index,
	input  logic [TEMP_WIDTH-1:0]                 cfg_data
);

	localparam int TW = TEMP_WIDTH;
	localparam int CW = $clog2(MAX_CORES + 1);
	localparam int OW = ((TW + RES_EXTRA_BITS + 7) / 8) * 8;
	localparam logic signed [TW-1:0] MOST_NEG = {1'b1, {(TW-1){1'b0}}};
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_CORES);

	// Configuration registers.
	logic signed [TW-1:0] clamp_low_q, clamp_high_q;
	logic signed [TW-1:0] warn_low_q, warn_high_q, crit_low_q, crit_high_q;

	// Stage 1: the accepted request as it came in.
	logic                 vld_s1, ok_s1, last_s1;
	logic signed [TW-1:0] rd_s1;

	// Round accumulation.
	logic signed [TW-1:0] max_q, max_nx;
	logic [CW-1:0]        cnt_q, cnt_nx;

	// Stage 2: maximum and count of a finished round.
	logic                 vld_s2;
	logic signed [TW-1:0] max_s2;
	logic [CW-1:0]        cnt_s2;

	// Stage 3: clamped maximum.
	logic                 vld_s3, func_s3;
	logic signed [TW-1:0] temp_s3;
	logic [CW-1:0]        cnt_s3;

	// Alarm state and the value reported by the last functional round.
	logic [ALARM_COUNT-1:0] alarm_q;
	logic signed [TW-1:0]   last_val_q;

	// Output register.
	logic          out_vld_q;
	logic [OW-1:0] out_data_q;

	// Pipeline flow.
	logic adv1, adv2, adv3;
	logic s2_free, s3_free, out_free;
	logic in_take;

	logic signed [TW-1:0]   clamp_lo_fix, clamp_val;
	logic [ALARM_COUNT-1:0] alarm_nx, alarm_out, edge_out;
	logic signed [TW-1:0]   agg_out;
	logic [CW+VALID_CORES_WIDTH-1:0] cnt_ext;
	logic [OW-1:0]          out_data_nx;

	// The output register frees up when its result is taken; each stage frees up
	// when it is empty or moves on in the same cycle. Readings that do not close a
	// round are folded into the accumulator and never enter stage 2.
	assign out_free = !out_vld_q || m_tready;
	assign adv3     = vld_s3 && out_free;
	assign s3_free  = !vld_s3 || adv3;
	assign adv2     = vld_s2 && s3_free;
	assign s2_free  = !vld_s2 || adv2;
	assign adv1     = vld_s1 && (!last_s1 || s2_free);
	assign s_tready = !vld_s1 || adv1;
	assign in_take  = s_tvalid && s_tready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clamp_low_q  <= TW'(CLAMP_LOW_RESET);
			clamp_high_q <= TW'(CLAMP_HIGH_RESET);
			warn_low_q   <= TW'(WARN_LOW_RESET);
			warn_high_q  <= TW'(WARN_HIGH_RESET);
			crit_low_q   <= TW'(CRIT_LOW_RESET);
			crit_high_q  <= TW'(CRIT_HIGH_RESET);
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_CLAMP_LOW:  clamp_low_q  <= cfg_data;
				REG_CLAMP_HIGH: clamp_high_q <= cfg_data;
				REG_WARN_LOW:   warn_low_q   <= cfg_data;
				REG_WARN_HIGH:  warn_high_q  <= cfg_data;
				REG_CRIT_LOW:   crit_low_q   <= cfg_data;
				REG_CRIT_HIGH:  crit_high_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// The first valid reading of a round always replaces the maximum; the count
	// stops at the number of cores.
	always_comb begin
		max_nx = max_q;
		cnt_nx = cnt_q;
		if (ok_s1) begin
			if (cnt_q == '0 || rd_s1 > max_q) begin
				max_nx = rd_s1;
			end
			if (cnt_q < CNT_MAX) begin
				cnt_nx = cnt_q + CW'(1);
			end
		end
	end

	// Clamp to the low bound first and then to the high bound, so inverted bounds
	// give the high bound.
	always_comb begin
		clamp_lo_fix = (max_s2 < clamp_low_q) ? clamp_low_q : max_s2;
		clamp_val    = (clamp_lo_fix > clamp_high_q) ? clamp_high_q : clamp_lo_fix;
	end

	// Alarm levels from the clamped value. An empty round reports the previous
	// value and alarms with no edges.
	always_comb begin
		alarm_nx                = '0;
		alarm_nx[ALM_WARN_HIGH] = (temp_s3 >= warn_high_q);
		alarm_nx[ALM_WARN_LOW]  = (temp_s3 <= warn_low_q);
		alarm_nx[ALM_CRIT_HIGH] = (temp_s3 >= crit_high_q);
		alarm_nx[ALM_CRIT_LOW]  = (temp_s3 <= crit_low_q);
		if (func_s3) begin
			agg_out   = temp_s3;
			alarm_out = alarm_nx;
			edge_out  = alarm_nx ^ alarm_q;
		end else begin
			agg_out   = last_val_q;
			alarm_out = alarm_q;
			edge_out  = '0;
		end
		cnt_ext     = {{VALID_CORES_WIDTH{1'b0}}, cnt_s3};
		out_data_nx = OW'({edge_out, alarm_out, cnt_ext[VALID_CORES_WIDTH-1:0],
			func_s3, agg_out});
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			vld_s3     <= 1'b0;
			out_vld_q  <= 1'b0;
			max_q      <= MOST_NEG;
			cnt_q      <= '0;
			alarm_q    <= '0;
			last_val_q <= '0;
		end else begin
			if (in_take) begin
				vld_s1 <= 1'b1;
			end else if (adv1) begin
				vld_s1 <= 1'b0;
			end

			if (adv1) begin
				if (last_s1) begin
					max_q <= MOST_NEG;
					cnt_q <= '0;
				end else begin
					max_q <= max_nx;
					cnt_q <= cnt_nx;
				end
			end

			if (adv1 && last_s1) begin
				vld_s2 <= 1'b1;
			end else if (adv2) begin
				vld_s2 <= 1'b0;
			end

			if (adv2) begin
				vld_s3 <= 1'b1;
			end else if (adv3) begin
				vld_s3 <= 1'b0;
			end

			if (adv3) begin
				out_vld_q <= 1'b1;
				if (func_s3) begin
					alarm_q    <= alarm_nx;
					last_val_q <= temp_s3;
				end
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_take) begin
			rd_s1   <= $signed(s_tdata[TW-1:0]);
			ok_s1   <= s_tuser;
			last_s1 <= s_tlast;
		end
		if (adv1 && last_s1) begin
			max_s2 <= max_nx;
			cnt_s2 <= cnt_nx;
		end
		if (adv2) begin
			temp_s3 <= clamp_val;
			cnt_s3  <= cnt_s2;
			func_s3 <= (cnt_s2 != '0);
		end
		if (adv3) begin
			out_data_q <= out_data_nx;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

endmodule

>>> rtl/core/ctmon_checker.sv
// Port-level checker of the core temperature maximum threshold monitor and its binding.
module ctmon_checker
	import ctmon_pkg::*;
#(
	parameter int TEMP_WIDTH = DEF_TEMP_WIDTH
) (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  m_tvalid,
	input logic                                  m_tready,
	input logic [((TEMP_WIDTH+RES_EXTRA_BITS+7)/8)*8-1:0] m_tdata
);

	localparam int FUNC_BIT = TEMP_WIDTH;
	localparam int CNT_LO   = TEMP_WIDTH + 1;
	localparam int CNT_HI   = CNT_LO + VALID_CORES_WIDTH - 1;
	localparam int EDGE_LO  = CNT_HI + 1 + ALARM_COUNT;
	localparam int EDGE_HI  = EDGE_LO + ALARM_COUNT - 1;

	logic                         res_func;
	logic [VALID_CORES_WIDTH-1:0] res_cnt;
	logic [ALARM_COUNT-1:0]       res_edges;

	assign res_func  = m_tdata[FUNC_BIT];
	assign res_cnt   = m_tdata[CNT_HI:CNT_LO];
	assign res_edges = m_tdata[EDGE_HI:EDGE_LO];

	// A waiting result is held until it is taken.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed or vanished while stalled");

	// An empty round carries no count and no alarm edges.
	a_empty_round: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !res_func |-> res_cnt == '0 && res_edges == '0)
		else $error("empty round reports a count or an edge");

	// A functional round saw at least one valid reading.
	a_func_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_func |-> res_cnt != '0)
		else $error("functional round with zero valid cores");

	// No result is shown while reset is held.
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("result valid during reset");

endmodule

bind core_temp_max_threshold_monitor_top ctmon_checker #(
	.TEMP_WIDTH(TEMP_WIDTH)
) u_ctmon_checker (.*);
